// ----- rtl/core/ptam_pkg.sv -----
// Shared types and constants of the peer table.
package ptam_pkg;
   localparam int MaxPeersDefault = 8;
   localparam int TimeoutMsDefault = 5000;
   localparam int MacW = 48;
   localparam int LevelW = 16;
   localparam int ZoneW = 8;
   localparam int TimeW = 32;
   localparam int CountW = 4;
   localparam int CsrIdxW = 2;
   localparam int CsrDataW = 8;

   typedef enum logic [1:0] {
      OP_REPORT = 2'd0,
      OP_TICK   = 2'd1,
      OP_QUERY  = 2'd2,
      OP_SPARE  = 2'd3
   } op_type;

   localparam logic [CsrIdxW-1:0] CSR_GROUP_ENABLED = 2'd0;
   localparam logic [CsrIdxW-1:0] CSR_COMBINE_MODE  = 2'd1;
   localparam logic [CsrIdxW-1:0] CSR_OWN_ZONES     = 2'd2;
   localparam logic [CsrIdxW-1:0] CSR_OWN_FOLLOWS   = 2'd3;

   // Phases broadcast to every cell.
   typedef enum logic [1:0] {
      PH_IDLE   = 2'd0,
      PH_SCAN   = 2'd1,
      PH_COMMIT = 2'd2,
      PH_AGE    = 2'd3
   } phase_type;

   // Token passed along the chain during a scan.
   typedef struct packed {
      logic             hit;
      logic             has_free;
      logic             has_old;
      logic [TimeW-1:0] old_time;
      logic [5:0]       slot;
   } scan_type;

   // Running aggregates passed along the chain.
   typedef struct packed {
      logic signed [LevelW-1:0] loud;
      logic signed [LevelW+5:0] sum;
      logic [6:0]               cnt;
      logic [ZoneW-1:0]         seen;
      logic [ZoneW-1:0]         twice;
   } agg_type;

   typedef struct packed {
      phase_type        phase;
      logic [MacW-1:0]  mac;
      logic [LevelW-1:0] level;
      logic [ZoneW-1:0] zones;
      logic             follows;
      logic [TimeW-1:0] now;
      logic [5:0]       slot;
   } bcast_type;
endpackage

// ----- rtl/core/ptam_cell.sv -----
// One table entry with its scan and aggregate stages.
module ptam_cell
   import ptam_pkg::*;
#(
   parameter int Index = 0,
   parameter int TimeoutMs = TimeoutMsDefault
) (
   input  logic      clock,
   input  logic      reset,
   input  bcast_type bc,
   input  logic      step,
   input  scan_type  scan_i,
   output scan_type  scan_o,
   input  agg_type   agg_i,
   output agg_type   agg_o,
   output logic      valid_o
);
   logic              valid_ff, valid_in;
   logic [MacW-1:0]   mac_ff;
   logic signed [LevelW-1:0] level_ff;
   logic [ZoneW-1:0]  zones_ff;
   logic              follows_ff;
   logic [TimeW-1:0]  heard_ff;
   logic [TimeW-1:0]  age;
   scan_type          scan_ff, scan_in;
   agg_type           agg_ff, agg_in;

   assign age = bc.now - heard_ff;
   assign valid_o = valid_ff;
   assign scan_o = scan_ff;
   assign agg_o = agg_ff;

   always_comb begin
      scan_in = scan_i;
      if (!scan_i.hit) begin
         if (valid_ff) begin
            if (mac_ff == bc.mac) begin
               scan_in.hit = 1'b1;
               scan_in.slot = 6'(Index);
            end else if (!scan_i.has_free &&
                         (!scan_i.has_old || heard_ff < scan_i.old_time)) begin
               scan_in.has_old = 1'b1;
               scan_in.old_time = heard_ff;
               scan_in.slot = 6'(Index);
            end
         end else if (!scan_i.has_free) begin
            scan_in.has_free = 1'b1;
            scan_in.slot = 6'(Index);
         end
      end
      agg_in = agg_i;
      if (valid_ff) begin
         if (level_ff > agg_i.loud) agg_in.loud = level_ff;
         agg_in.sum = agg_i.sum + (LevelW+6)'(level_ff);
         agg_in.cnt = agg_i.cnt + 7'd1;
         if (follows_ff) begin
            agg_in.twice = agg_i.twice | (agg_i.seen & zones_ff);
            agg_in.seen = agg_i.seen | zones_ff;
         end
      end
      valid_in = valid_ff;
      if (step && bc.phase == PH_COMMIT && bc.slot == 6'(Index)) valid_in = 1'b1;
      if (step && bc.phase == PH_AGE && valid_ff && age >= TimeW'(TimeoutMs))
         valid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      scan_ff <= scan_in;
      agg_ff <= agg_in;
      if (step && bc.phase == PH_COMMIT && bc.slot == 6'(Index)) begin
         mac_ff <= bc.mac;
         level_ff <= bc.level;
         zones_ff <= bc.zones;
         follows_ff <= bc.follows;
         heard_ff <= bc.now;
      end
   end
endmodule

// ----- rtl/core/ptam_div.sv -----
// Restoring signed divider for the average level.
module ptam_div
   import ptam_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   input  logic signed [LevelW+5:0] num,
   input  logic [6:0]               den,
   output logic                     done,
   output logic signed [LevelW-1:0] quo
);
   localparam int NW = LevelW + 6;
   logic [NW-1:0] q_ff, q_in;
   logic [7:0]    r_ff, r_in;
   logic [6:0]    d_ff;
   logic          neg_ff, busy_ff;
   logic [4:0]    n_ff;
   logic [7:0]    trial;
   logic [NW-1:0] quo_full;

   always_comb begin
      trial = {r_ff[6:0], q_ff[NW-1]};
      q_in = {q_ff[NW-2:0], 1'b0};
      r_in = trial;
      if (trial >= {1'b0, d_ff}) begin
         r_in = trial - {1'b0, d_ff};
         q_in[0] = 1'b1;
      end
      quo_full = neg_ff ? -q_ff : q_ff;
   end
   assign quo = quo_full[LevelW-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done <= 1'b0;
      end else begin
         done <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            n_ff <= 5'(NW);
            q_ff <= num[NW-1] ? -num : num;
            neg_ff <= num[NW-1];
            d_ff <= den;
            r_ff <= 8'd0;
         end else if (busy_ff) begin
            q_ff <= q_in;
            r_ff <= r_in;
            n_ff <= n_ff - 5'd1;
            if (n_ff == 5'd1) begin
               busy_ff <= 1'b0;
               done <= 1'b1;
            end
         end
      end
   end
endmodule

// ----- rtl/core/peer_table_with_aging_and_level_merge_core.sv -----
// Top level of the peer table with aging and level merge.
// Each item walks a chain of MAX_PEERS entry cells that pass a scan token and running
// aggregates one cell per cycle: the scan finds the slot, the work step commits a report
// or ages the table on a tick, the gather collects the aggregates, and the result is
// formed, for averaging after a bit-serial divide. The next item is taken only after the
// result leaves and the block is back in idle; req_stall is high until then.
module peer_table_with_aging_and_level_merge_core
   import ptam_pkg::*;
#(
   parameter int MAX_PEERS = MaxPeersDefault,
   parameter int TIMEOUT_MS = TimeoutMsDefault
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  logic [1:0]               req_op,
   input  logic [MacW-1:0]          req_peer_mac,
   input  logic signed [LevelW-1:0] req_report_level,
   input  logic [ZoneW-1:0]         req_report_zones,
   input  logic                     req_report_follows,
   input  logic signed [LevelW-1:0] req_own_level,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output logic signed [LevelW-1:0] rsp_group_level,
   output logic [CountW-1:0]        rsp_peer_count,
   output logic [ZoneW-1:0]         rsp_zone_coverage,
   output logic [ZoneW-1:0]         rsp_zone_overlap,
   output logic                     rsp_evicted,
   input  logic                     csr_write,
   input  logic [CsrIdxW-1:0]       csr_index,
   input  logic [CsrDataW-1:0]      csr_data
);
   typedef enum logic [2:0] {S_IDLE, S_SCAN, S_WORK, S_GATHER, S_DIV, S_OUT} state_type;
   state_type state_ff;
   logic group_enabled_ff, combine_mode_ff, own_follows_ff;
   logic [ZoneW-1:0] own_zones_ff;
   op_type op_ff;
   logic [MacW-1:0] mac_ff;
   logic [LevelW-1:0] rlevel_ff;
   logic [ZoneW-1:0] rzones_ff;
   logic rfollows_ff;
   logic signed [LevelW-1:0] own_ff;
   logic [TimeW-1:0] now_ff;
   logic [5:0] slot_ff;
   logic [5:0] wait_ff;
   logic evict_ff;
   agg_type agg_ff;
   logic div_start, div_done;
   logic signed [LevelW-1:0] div_quo;
   bcast_type bc;
   logic step;
   scan_type scan_c [MAX_PEERS+1];
   agg_type agg_c [MAX_PEERS+1];
   logic [MAX_PEERS-1:0] valid_v;

   assign step = state_ff == S_WORK;
   always_comb begin
      bc.phase = PH_IDLE;
      if (op_ff == OP_REPORT) bc.phase = PH_COMMIT;
      else if (op_ff == OP_TICK) bc.phase = PH_AGE;
      bc.mac = mac_ff;
      bc.level = rlevel_ff;
      bc.zones = rzones_ff;
      bc.follows = rfollows_ff;
      bc.now = now_ff;
      bc.slot = slot_ff;
   end
   assign scan_c[0] = '0;
   always_comb begin
      agg_c[0].loud = own_ff;
      agg_c[0].sum = (LevelW+6)'(own_ff);
      agg_c[0].cnt = 7'd1;
      agg_c[0].seen = own_follows_ff ? own_zones_ff : '0;
      agg_c[0].twice = '0;
   end

   for (genvar i = 0; i < MAX_PEERS; i++) begin : g_cell
      ptam_cell #(.Index(i), .TimeoutMs(TIMEOUT_MS)) u_cell (
         .clock(clock), .reset(reset), .bc(bc), .step(step),
         .scan_i(scan_c[i]), .scan_o(scan_c[i+1]),
         .agg_i(agg_c[i]), .agg_o(agg_c[i+1]), .valid_o(valid_v[i]));
   end

   assign div_start = state_ff == S_GATHER && wait_ff == '0 &&
                      group_enabled_ff && combine_mode_ff;
   ptam_div u_div (.clock(clock), .reset(reset), .start(div_start),
      .num(agg_c[MAX_PEERS].sum), .den(agg_c[MAX_PEERS].cnt), .done(div_done),
      .quo(div_quo));

   assign req_stall = state_ff != S_IDLE;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         rsp_valid <= 1'b0;
         now_ff <= '0;
         group_enabled_ff <= 1'b0;
         combine_mode_ff <= 1'b0;
         own_zones_ff <= '0;
         own_follows_ff <= 1'b0;
      end else begin
         if (csr_write) begin
            case (csr_index)
               CSR_GROUP_ENABLED: group_enabled_ff <= csr_data[0];
               CSR_COMBINE_MODE:  combine_mode_ff <= csr_data[0];
               CSR_OWN_ZONES:     own_zones_ff <= csr_data;
               CSR_OWN_FOLLOWS:   own_follows_ff <= csr_data[0];
               default: ;
            endcase
         end
         case (state_ff)
            S_IDLE: if (req_valid) begin
               op_ff <= op_type'(req_op);
               mac_ff <= req_peer_mac;
               rlevel_ff <= req_report_level;
               rzones_ff <= req_report_zones;
               rfollows_ff <= req_report_follows;
               own_ff <= req_own_level;
               if (req_op == OP_TICK) now_ff <= now_ff + 1'b1;
               wait_ff <= 6'(MAX_PEERS);
               state_ff <= S_SCAN;
            end
            S_SCAN: begin
               if (wait_ff != '0) begin
                  wait_ff <= wait_ff - 6'd1;
               end else begin
                  slot_ff <= scan_c[MAX_PEERS].slot;
                  evict_ff <= op_ff == OP_REPORT && !scan_c[MAX_PEERS].hit &&
                              !scan_c[MAX_PEERS].has_free;
                  state_ff <= S_WORK;
               end
            end
            S_WORK: begin
               wait_ff <= 6'(MAX_PEERS);
               state_ff <= S_GATHER;
            end
            S_GATHER: begin
               if (wait_ff != '0) begin
                  wait_ff <= wait_ff - 6'd1;
               end else begin
                  agg_ff <= agg_c[MAX_PEERS];
                  state_ff <= S_DIV;
               end
            end
            S_DIV: begin
               if (!(group_enabled_ff && combine_mode_ff) || div_done) begin
                  rsp_group_level <= !group_enabled_ff ? own_ff :
                                     combine_mode_ff ? div_quo : agg_ff.loud;
                  rsp_peer_count <= (agg_ff.cnt - 7'd1 > 7'd15) ? 4'd15 :
                                    4'(agg_ff.cnt - 7'd1);
                  rsp_zone_coverage <= agg_ff.seen;
                  rsp_zone_overlap <= agg_ff.twice;
                  rsp_evicted <= evict_ff;
                  rsp_valid <= 1'b1;
                  state_ff <= S_OUT;
               end
            end
            S_OUT: if (!rsp_stall) begin
               rsp_valid <= 1'b0;
               state_ff <= S_IDLE;
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> state_ff == S_OUT) else $error("result outside output state");
   assert property (@(posedge clock) disable iff (reset)
      state_ff == S_SCAN && wait_ff == '0 |=> state_ff == S_WORK)
      else $error("scan did not advance");
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_evicted |-> op_ff == OP_REPORT) else $error("evict on non-report");
endmodule
